// ----- hw/rtl/pmu_pkg.sv -----
// Shared constants, command codes and controller/datapath link types of the polynomial multiplier.
package pmu_pkg;

   localparam int MAX_TERMS = 16;
   localparam int ADDR_W    = $clog2(MAX_TERMS);
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int COEF_W    = 32;
   localparam int POWER_W   = 5;
   localparam int SUM_W     = POWER_W + 1;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int ACC_W     = PROD_W + ADDR_W;
   localparam int FRAC_W    = 16;

   typedef enum logic [1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_MULTIPLY    = 2'd2
   } command_type;

   typedef struct packed {
      logic                     wr_first;
      logic                     wr_second;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [COEF_W-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_first_addr;
      logic [ADDR_W-1:0]        rd_second_addr;
      logic                     acc_clear;
      logic                     out_load;
      logic                     out_zero;
      logic [POWER_W-1:0]       out_power;
      logic                     out_last;
      logic                     out_empty;
      logic                     out_overflow;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/pmu_channels.sv -----
// Request and response channel interfaces of the polynomial multiplier.
interface pmu_req_if import pmu_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic signed [COEF_W-1:0] coefficient;

   modport source (output valid, output command, output coefficient, input ready);
   modport sink   (input valid, input command, input coefficient, output ready);
endinterface

interface pmu_rsp_if import pmu_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] product_coefficient;
   logic [POWER_W-1:0]       power;
   logic                     last;
   logic                     empty_result;
   logic                     overflow;

   modport source (output valid, output product_coefficient, output power, output last,
                   output empty_result, output overflow, input ready);
   modport sink   (input valid, input product_coefficient, input power, input last,
                   input empty_result, input overflow, output ready);
endinterface

// ----- hw/rtl/pmu_datapath.sv -----
// Operand stores, multiply-accumulate pipeline, rounding and the response register.
module pmu_datapath
   import pmu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   pmu_rsp_if.source     rsp_chan
);

   localparam int RND_W = ACC_W + 1;
   localparam int Q_W   = RND_W - FRAC_W;

   logic signed [COEF_W-1:0] first_mem [MAX_TERMS];
   logic signed [COEF_W-1:0] second_mem [MAX_TERMS];

   logic signed [COEF_W-1:0] a_rd_ff;
   logic signed [COEF_W-1:0] b_rd_ff;
   logic                     rd_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   logic signed [RND_W-1:0]  rounded;
   logic signed [Q_W-1:0]    quot;
   logic                     sat_pos;
   logic                     sat_neg;
   logic signed [COEF_W-1:0] sat_value;

   logic                     rsp_valid_ff;
   logic signed [COEF_W-1:0] coef_ff;
   logic [POWER_W-1:0]       power_ff;
   logic                     last_ff;
   logic                     empty_ff;
   logic                     ovf_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         first_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.wr_second) begin
         second_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         a_rd_ff <= first_mem[cmd.rd_first_addr];
         b_rd_ff <= second_mem[cmd.rd_second_addr];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.rd_en;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Round to nearest with ties upward, then clamp to the signed 32-bit range.
   always_comb begin
      rounded   = RND_W'(acc_ff) + RND_W'(1 << (FRAC_W - 1));
      quot      = Q_W'(rounded >>> FRAC_W);
      sat_pos   = !quot[Q_W-1] && (|quot[Q_W-2:COEF_W-1]);
      sat_neg   = quot[Q_W-1] && !(&quot[Q_W-2:COEF_W-1]);
      sat_value = quot[COEF_W-1:0];
      if (sat_pos) begin
         sat_value = {1'b0, {(COEF_W-1){1'b1}}};
      end else if (sat_neg) begin
         sat_value = {1'b1, {(COEF_W-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         coef_ff  <= cmd.out_zero ? '0 : sat_value;
         power_ff <= cmd.out_power;
         last_ff  <= cmd.out_last;
         empty_ff <= cmd.out_empty;
         ovf_ff   <= cmd.out_overflow;
      end
   end

   assign status.out_free              = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.product_coefficient = coef_ff;
   assign rsp_chan.power               = power_ff;
   assign rsp_chan.last                = last_ff;
   assign rsp_chan.empty_result        = empty_ff;
   assign rsp_chan.overflow            = ovf_ff;

endmodule

// ----- hw/rtl/pmu_ctrl.sv -----
// Controller: operand counts, load handling and the per-term multiply-accumulate sequencer.
module pmu_ctrl
   import pmu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pmu_req_if.sink       req_chan,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MAC     = 5'b00010,
      ST_DRAIN   = 5'b00100,
      ST_ROUND   = 5'b01000,
      ST_SPECIAL = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   first_count_ff, first_count_in;
   logic [CNT_W-1:0]   second_count_ff, second_count_in;
   logic               overflow_seen_ff, overflow_seen_in;
   logic               first_zero_ff, first_zero_in;
   logic               second_zero_ff, second_zero_in;
   logic [POWER_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [ADDR_W-1:0]  i_end_ff, i_end_in;
   logic [POWER_W-1:0] last_k_ff, last_k_in;
   logic               drain_ff, drain_in;
   logic               special_empty_ff, special_empty_in;

   logic               accept;
   logic [POWER_W-1:0] k_next;
   logic [POWER_W-1:0] j_index;
   logic [SUM_W-1:0]   count_sum;

   // Lowest first-operand index that pairs with a valid second-operand index for power k.
   function automatic logic [ADDR_W-1:0] term_start(logic [POWER_W-1:0] k,
                                                    logic [CNT_W-1:0] n2);
      logic [SUM_W-1:0] k_ext;
      logic [SUM_W-1:0] n_ext;
      logic [SUM_W-1:0] diff;
      k_ext = {1'b0, k};
      n_ext = {{(SUM_W-CNT_W){1'b0}}, n2};
      diff  = '0;
      if (k_ext >= n_ext) begin
         diff = k_ext - n_ext + SUM_W'(1);
      end
      return diff[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] term_end(logic [POWER_W-1:0] k,
                                                  logic [CNT_W-1:0] n1);
      logic [SUM_W-1:0] k_ext;
      logic [SUM_W-1:0] n_ext;
      logic [SUM_W-1:0] top;
      k_ext = {1'b0, k};
      n_ext = {{(SUM_W-CNT_W){1'b0}}, n1};
      top   = k_ext;
      if (k_ext >= n_ext) begin
         top = n_ext - SUM_W'(1);
      end
      return top[ADDR_W-1:0];
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign k_next         = k_ff + POWER_W'(1);
   assign j_index        = k_ff - {{(POWER_W-ADDR_W){1'b0}}, i_ff};
   assign count_sum      = {{(SUM_W-CNT_W){1'b0}}, first_count_ff}
                         + {{(SUM_W-CNT_W){1'b0}}, second_count_ff};

   always_comb begin
      state_in         = state_ff;
      first_count_in   = first_count_ff;
      second_count_in  = second_count_ff;
      overflow_seen_in = overflow_seen_ff;
      first_zero_in    = first_zero_ff;
      second_zero_in   = second_zero_ff;
      k_in             = k_ff;
      i_in             = i_ff;
      i_end_in         = i_end_ff;
      last_k_in        = last_k_ff;
      drain_in         = drain_ff;
      special_empty_in = special_empty_ff;

      cmd                = '0;
      cmd.wr_addr        = '0;
      cmd.wr_data        = req_chan.coefficient;
      cmd.rd_first_addr  = i_ff;
      cmd.rd_second_addr = j_index[ADDR_W-1:0];
      cmd.out_power      = k_ff;
      cmd.out_last       = (k_ff == last_k_ff);
      cmd.out_empty      = 1'b0;
      cmd.out_overflow   = overflow_seen_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.command)
                  CMD_LOAD_FIRST: begin
                     if (first_count_ff < CNT_W'(MAX_TERMS)) begin
                        cmd.wr_first   = 1'b1;
                        cmd.wr_addr    = first_count_ff[ADDR_W-1:0];
                        first_count_in = first_count_ff + CNT_W'(1);
                        if (first_count_ff == '0) begin
                           first_zero_in = (req_chan.coefficient == '0);
                        end
                     end else begin
                        overflow_seen_in = 1'b1;
                     end
                  end
                  CMD_LOAD_SECOND: begin
                     if (second_count_ff < CNT_W'(MAX_TERMS)) begin
                        cmd.wr_second   = 1'b1;
                        cmd.wr_addr     = second_count_ff[ADDR_W-1:0];
                        second_count_in = second_count_ff + CNT_W'(1);
                        if (second_count_ff == '0) begin
                           second_zero_in = (req_chan.coefficient == '0);
                        end
                     end else begin
                        overflow_seen_in = 1'b1;
                     end
                  end
                  CMD_MULTIPLY: begin
                     if (first_count_ff == '0 || second_count_ff == '0) begin
                        special_empty_in = 1'b1;
                        state_in         = ST_SPECIAL;
                     end else if ((first_count_ff == CNT_W'(1) && first_zero_ff) ||
                                  (second_count_ff == CNT_W'(1) && second_zero_ff)) begin
                        special_empty_in = 1'b0;
                        state_in         = ST_SPECIAL;
                     end else begin
                        k_in          = '0;
                        i_in          = '0;
                        i_end_in      = '0;
                        last_k_in     = POWER_W'(count_sum - SUM_W'(2));
                        cmd.acc_clear = 1'b1;
                        state_in      = ST_MAC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            cmd.rd_en = 1'b1;
            if (i_ff == i_end_ff) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               i_in = i_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            // The drain state lets the last product pass the read and multiply registers.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (k_ff == last_k_ff) begin
                  first_count_in   = '0;
                  second_count_in  = '0;
                  overflow_seen_in = 1'b0;
                  state_in         = ST_IDLE;
               end else begin
                  k_in          = k_next;
                  i_in          = term_start(k_next, second_count_ff);
                  i_end_in      = term_end(k_next, first_count_ff);
                  cmd.acc_clear = 1'b1;
                  state_in      = ST_MAC;
               end
            end
         end
         ST_SPECIAL: begin
            cmd.out_power = '0;
            cmd.out_last  = 1'b1;
            cmd.out_empty = special_empty_ff;
            cmd.out_zero  = 1'b1;
            if (status.out_free) begin
               cmd.out_load     = 1'b1;
               first_count_in   = '0;
               second_count_in  = '0;
               overflow_seen_in = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         first_count_ff   <= '0;
         second_count_ff  <= '0;
         overflow_seen_ff <= 1'b0;
         first_zero_ff    <= 1'b0;
         second_zero_ff   <= 1'b0;
         k_ff             <= '0;
         i_ff             <= '0;
         i_end_ff         <= '0;
         last_k_ff        <= '0;
         drain_ff         <= 1'b0;
         special_empty_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         first_count_ff   <= first_count_in;
         second_count_ff  <= second_count_in;
         overflow_seen_ff <= overflow_seen_in;
         first_zero_ff    <= first_zero_in;
         second_zero_ff   <= second_zero_in;
         k_ff             <= k_in;
         i_ff             <= i_in;
         i_end_ff         <= i_end_in;
         last_k_ff        <= last_k_in;
         drain_ff         <= drain_in;
         special_empty_ff <= special_empty_in;
      end
   end

endmodule

// ----- hw/rtl/polynomial_multiply_unit.sv -----
// Top level of the polynomial multiplier: controller, datapath and checks.
//
//   channel    direction  payload
//   req_chan   in         command, coefficient
//   rsp_chan   out        product_coefficient, power, last, empty_result, overflow
//
// A load transaction leaves the request side open. A multiply with n1 and n2 stored
// coefficients closes the request side from when it is taken until its last term is
// loaded for output; the single multiply-accumulate unit walks every product pair
// through a read, a multiply and an accumulate register, then drains and rounds each term.
// An empty or zero operand gives its one result from the special state, with no multiply.
// Reset is synchronous and needs no clearing pass; the stores are undefined until loaded.
// A stalled response holds in the output register while the next term is computed.
module polynomial_multiply_unit
   import pmu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pmu_req_if.sink   req_chan,
   pmu_rsp_if.source rsp_chan
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   pmu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .status   (dp_status),
      .cmd      (dp_cmd)
   );

   pmu_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .status   (dp_status),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   // A result is never written over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> dp_status.out_free)
      else $error("output register overwritten while occupied");

   // Store reads only happen while no request transaction can be taken.
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rd_en |-> !req_chan.ready)
      else $error("store read while accepting requests");

   // A loaded result is presented in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |=> rsp_chan.valid)
      else $error("loaded result not presented");

   // Writes to the stores come only from accepted load transactions.
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.wr_first || dp_cmd.wr_second) |-> (req_chan.valid && req_chan.ready))
      else $error("store write without a request transaction");
`endif

endmodule

// ----- tb/polynomial_multiply_unit_tb.sv -----
// Self-checking testbench of the polynomial multiplier: operand loads, products, stalls.
module polynomial_multiply_unit_tb;
   import pmu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ACCUM_W      = PROD_W + 8;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int PACE_STEADY  = 0;
   localparam int PACE_PATTERN = 1;
   localparam int PACE_RANDOM  = 2;

   localparam logic signed [COEF_W-1:0]  COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]  COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [ACCUM_W-1:0] ROUND_HALF = 2 ** (FRAC_W - 1);
   localparam logic [COEF_W-1:0] EDGE_COEFS [8] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000
   };

   typedef struct packed {
      logic signed [COEF_W-1:0] product_coefficient;
      logic [POWER_W-1:0]       power;
      logic                     last;
      logic                     empty_result;
      logic                     overflow;
   } product_term_type;

   logic clock = 1'b0;
   logic reset;

   pmu_req_if req_chan ();
   pmu_rsp_if rsp_chan ();

   polynomial_multiply_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Operand stores as the block should hold them.
   logic signed [COEF_W-1:0] first_coef  [MAX_TERMS];
   logic signed [COEF_W-1:0] second_coef [MAX_TERMS];
   int   first_len      = 0;
   int   second_len     = 0;
   logic store_overflow = 1'b0;

   product_term_type expected_terms [$];

   int failures            = 0;
   int items_accepted      = 0;
   int terms_checked       = 0;
   int multiplies          = 0;
   int overflow_multiplies = 0;
   int saturated_terms     = 0;
   int cycle_count         = 0;

   bit sender_gaps = 1'b0;
   int burst_left  = 0;

   int          hold_tag   = 0;
   int          hold_seen  = 0;
   int          hold_left  = 0;
   int          pace_style = PACE_STEADY;
   int          pace_left  = 0;
   logic [15:0] stall_bits = '0;

   // Exact convolution sum for one power, rounded half up and clipped to 32 bits.
   function automatic logic signed [COEF_W-1:0] rounded_term(input int k);
      logic signed [ACCUM_W-1:0] sum;
      logic signed [COEF_W-1:0]  low;
      sum = '0;
      for (int i = 0; i < first_len; i++) begin
         if (k - i >= 0 && k - i < second_len) begin
            sum += first_coef[i] * second_coef[k - i];
         end
      end
      sum = (sum + ROUND_HALF) >>> FRAC_W;
      low = sum[COEF_W-1:0];
      if (sum == low) begin
         return low;
      end
      saturated_terms++;
      return (sum < 0) ? COEF_MIN : COEF_MAX;
   endfunction

   function automatic void add_term(input logic signed [COEF_W-1:0] value, input int power,
                                    input logic last, input logic empty_result);
      product_term_type term;
      term.product_coefficient = value;
      term.power               = POWER_W'(power);
      term.last                = last;
      term.empty_result        = empty_result;
      term.overflow            = store_overflow;
      expected_terms.push_back(term);
   endfunction

   function automatic void predict_request(input logic [1:0] command,
                                           input logic [COEF_W-1:0] coefficient);
      int total;
      case (command)
         CMD_LOAD_FIRST: begin
            if (first_len < MAX_TERMS) begin
               first_coef[first_len] = coefficient;
               first_len++;
            end else begin
               store_overflow = 1'b1;
            end
         end
         CMD_LOAD_SECOND: begin
            if (second_len < MAX_TERMS) begin
               second_coef[second_len] = coefficient;
               second_len++;
            end else begin
               store_overflow = 1'b1;
            end
         end
         CMD_MULTIPLY: begin
            multiplies++;
            if (store_overflow) begin
               overflow_multiplies++;
            end
            if (first_len == 0 || second_len == 0) begin
               add_term('0, 0, 1'b1, 1'b1);
            end else if ((first_len == 1 && first_coef[0] == 0) ||
                         (second_len == 1 && second_coef[0] == 0)) begin
               add_term('0, 0, 1'b1, 1'b0);
            end else begin
               total = first_len + second_len - 1;
               for (int k = 0; k < total; k++) begin
                  add_term(rounded_term(k), k, k == total - 1, 1'b0);
               end
            end
            first_len      = 0;
            second_len     = 0;
            store_overflow = 1'b0;
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input int power,
                                         input logic [COEF_W-1:0] want,
                                         input logic [COEF_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t ns: %s mismatch on power %0d: expected %h, actual %h",
                  $time, name, power, want, got);
      end
   endfunction

   task automatic check_term();
      product_term_type want;
      terms_checked++;
      if (expected_terms.size() == 0) begin
         failures++;
         $display("%0t ns: product term with nothing pending: expected none, %s",
                  $time, "actual");
         $display("   power %0d coefficient %h", rsp_chan.power,
                  rsp_chan.product_coefficient);
      end else begin
         want = expected_terms.pop_front();
         compare_field("product_coefficient", want.power, want.product_coefficient,
                       rsp_chan.product_coefficient);
         compare_field("power", want.power, want.power, rsp_chan.power);
         compare_field("last", want.power, want.last, rsp_chan.last);
         compare_field("empty_result", want.power, want.empty_result, rsp_chan.empty_result);
         compare_field("overflow", want.power, want.overflow, rsp_chan.overflow);
      end
   endtask

   // Response side: checks every transaction, then picks the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_term();
         end
         if (hold_seen != hold_tag) begin
            hold_seen      <= hold_tag;
            hold_left      <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (pace_left == 0) begin
            pace_style     <= $urandom_range(PACE_STEADY, PACE_RANDOM);
            stall_bits     <= 16'($urandom());
            pace_left      <= $urandom_range(20, 200);
            rsp_chan.ready <= 1'b1;
         end else begin
            pace_left  <= pace_left - 1;
            stall_bits <= {stall_bits[14:0], stall_bits[15]};
            case (pace_style)
               PACE_STEADY:  rsp_chan.ready <= 1'b1;
               PACE_PATTERN: rsp_chan.ready <= stall_bits[0] | stall_bits[5];
               default:      rsp_chan.ready <= $urandom_range(0, 3) != 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [COEF_W-1:0] random_coefficient();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         5:             return EDGE_COEFS[3'($urandom_range(0, 7))];
         default:       return $urandom();
      endcase
   endfunction

   function automatic int pick_size();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(5, MAX_TERMS) : $urandom_range(1, 4);
   endfunction

   // Called at a rising edge; returns at the edge where the transaction was taken.
   task automatic send_item(input logic [1:0] command, input logic [COEF_W-1:0] coefficient);
      if (sender_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= command;
      req_chan.coefficient <= coefficient;
      do @(posedge clock); while (!req_chan.ready);
      predict_request(command, coefficient);
      if (command != CMD_UNUSED) begin
         items_accepted++;
      end
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_terms.size() != 0);
   endtask

   // Loads both operands in random interleaving, then multiplies. With zero_operand set,
   // any operand of exactly one term is loaded with zero.
   task automatic run_product(input int first_terms, input int second_terms,
                              input bit zero_operand);
      int first_left;
      int second_left;
      first_left  = first_terms;
      second_left = second_terms;
      while (first_left + second_left > 0) begin
         if (second_left == 0 || (first_left != 0 && $urandom_range(0, 1) == 1)) begin
            send_item(CMD_LOAD_FIRST,
                      (zero_operand && first_terms == 1) ? 32'h0 : random_coefficient());
            first_left--;
         end else begin
            send_item(CMD_LOAD_SECOND,
                      (zero_operand && second_terms == 1) ? 32'h0 : random_coefficient());
            second_left--;
         end
         if ($urandom_range(0, 30) == 0) begin
            send_item(CMD_UNUSED, $urandom());
         end
      end
      send_item(CMD_MULTIPLY, $urandom());
   endtask

   task automatic test_special_operands();
      sender_gaps = 1'b0;
      send_item(CMD_MULTIPLY, 32'h0);
      send_item(CMD_LOAD_FIRST, 32'h0005_0000);
      send_item(CMD_MULTIPLY, 32'hFFFF_FFFF);
      send_item(CMD_LOAD_SECOND, 32'h0003_0000);
      send_item(CMD_MULTIPLY, 32'h0);
      send_item(CMD_LOAD_FIRST, 32'h0);
      send_item(CMD_LOAD_SECOND, 32'h0002_8000);
      send_item(CMD_LOAD_SECOND, 32'hFFFF_0000);
      send_item(CMD_MULTIPLY, 32'h0);
      // The unused command in the middle must leave the stores alone.
      send_item(CMD_LOAD_FIRST, 32'h0001_8000);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF);
      send_item(CMD_LOAD_SECOND, 32'h0);
      send_item(CMD_MULTIPLY, 32'h0);
   endtask

   task automatic test_rounding_and_saturation();
      // Half-way cases: plus one half rounds up, minus one half rounds to zero.
      send_item(CMD_LOAD_FIRST, 32'h0000_0001);
      send_item(CMD_LOAD_FIRST, 32'hFFFF_FFFF);
      send_item(CMD_LOAD_SECOND, 32'h0000_8000);
      send_item(CMD_MULTIPLY, 32'h0);
      send_item(CMD_LOAD_FIRST, 32'hFFFE_8000);
      send_item(CMD_LOAD_SECOND, 32'h0002_4000);
      send_item(CMD_MULTIPLY, 32'h0);
      // Largest magnitudes clip to both ends of the range.
      send_item(CMD_LOAD_FIRST, 32'h7FFF_FFFF);
      send_item(CMD_LOAD_FIRST, 32'h8000_0000);
      send_item(CMD_LOAD_SECOND, 32'h7FFF_FFFF);
      send_item(CMD_LOAD_SECOND, 32'h8000_0000);
      send_item(CMD_MULTIPLY, 32'h0);
      wait_all_results();
   endtask

   task automatic test_store_overflow();
      sender_gaps = 1'b1;
      run_product(MAX_TERMS + 1, 2, 1'b0);
      run_product(1, MAX_TERMS + 4, 1'b0);
      run_product(MAX_TERMS + 1, 0, 1'b0);
      run_product(1, MAX_TERMS + 2, 1'b1);
      run_product(MAX_TERMS, MAX_TERMS, 1'b0);
   endtask

   task automatic test_random_products();
      int target;
      int products;
      target   = items_accepted + 80;
      products = 0;
      while (items_accepted < target) begin
         if (products % 6 == 0) begin
            sender_gaps = $urandom_range(0, 3) != 0;
         end
         case ($urandom_range(0, 19))
            0: begin
               if ($urandom_range(0, 1) == 1) run_product(0, pick_size(), 1'b0);
               else run_product(pick_size(), 0, 1'b0);
            end
            1: begin
               if ($urandom_range(0, 1) == 1) begin
                  run_product($urandom_range(17, 19), pick_size(), 1'b0);
               end else begin
                  run_product(pick_size(), $urandom_range(17, 19), 1'b0);
               end
            end
            2: begin
               if ($urandom_range(0, 1) == 1) run_product(1, pick_size(), 1'b1);
               else run_product(pick_size(), 1, 1'b1);
            end
            default: run_product(pick_size(), pick_size(), 1'b0);
         endcase
         products++;
         if ($urandom_range(0, 9) == 0) begin
            wait_all_results();
         end
      end
   endtask

   task automatic test_response_backpressure();
      sender_gaps = 1'b0;
      wait_all_results();
      // The response side now refuses for a long stretch while products keep coming.
      hold_tag <= hold_tag + 1;
      repeat (5) begin
         run_product($urandom_range(2, 4), $urandom_range(2, 4), 1'b0);
      end
      wait_all_results();
   endtask

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_LOAD_FIRST;
      req_chan.coefficient <= '0;
      reset                <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_special_operands();
      test_rounding_and_saturation();
      test_store_overflow();
      test_random_products();
      test_response_backpressure();

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request transactions and %0d multiplies, %0d after an overflow.",
               items_accepted, multiplies, overflow_multiplies);
      $display("Checked %0d product terms, %0d clipped, under gaps and stalls on both sides.",
               terms_checked, saturated_terms);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
